>>> src/note_grid_to_midi_events_unit_macros.svh
// ----------------------------------------------------------------------------
// note_grid_to_midi_events_unit_macros
// assertion helpers shared by the note grid to midi event files
// ----------------------------------------------------------------------------
`ifndef NOTE_GRID_TO_MIDI_EVENTS_UNIT_MACROS_SVH
`define NOTE_GRID_TO_MIDI_EVENTS_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define NGME_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define NGME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ngme_pkg.sv
// ----------------------------------------------------------------------------
// ngme_pkg
// types, constants and helper functions for the note grid to midi event unit
// ----------------------------------------------------------------------------
package ngme_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BASE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TOP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_STEPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_INTERVALS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCUSSION_TRACK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_OFFSET     = 3'd5;

    localparam int SCALE_SLOTS = 12;
    localparam int IV_W        = 5;

    localparam logic [27:0] DELTA_MAX    = 28'h0FF_FFFF | 28'hF00_0000;
    localparam logic [3:0]  PERC_CHANNEL = 4'd9;
    localparam logic [7:0]  NOTE_OFF     = 8'h80;
    localparam logic [7:0]  NOTE_ON      = 8'h90;
    localparam logic [6:0]  VEL_OFF      = 7'd40;
    localparam logic [6:0]  VEL_ON       = 7'd63;

    localparam logic [6:0]  RST_SCALE_BASE  = 7'd60;
    localparam logic [6:0]  RST_SCALE_TOP   = 7'd127;
    localparam logic [3:0]  RST_SCALE_STEPS = 4'd7;

    typedef struct packed {
        logic [3:0] track_index;
        logic [7:0] note_code;
        logic       step_end;
    } grid_t;

    typedef struct packed {
        logic [27:0] delta_steps;
        logic [7:0]  status_byte;
        logic [6:0]  key;
        logic [6:0]  velocity;
        logic        last_event;
    } midi_t;

    typedef struct packed {
        logic [6:0]  scale_base;
        logic [6:0]  scale_top;
        logic [3:0]  scale_steps;
        logic [59:0] scale_intervals;
        logic [8:0]  percussion_track;   // two's complement, bit 8 set means none
        logic [7:0]  track_offset;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic plan;
        logic emit;
        logic second;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic       walk_done;
        logic       out_free;
        logic [1:0] ev_count;
    } sts_t;

    // residue mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [7:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = {2'b0, v[2:0]} + {2'b0, v[5:3]} + {3'b0, v[7:6]};
        s2 = {1'b0, s1[2:0]} + {2'b0, s1[4:3]};
        mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    function automatic logic [6:0] drum_key(input logic [2:0] sel);
        case (sel)
            3'd0:    drum_key = 7'd35;
            3'd1:    drum_key = 7'd36;
            3'd2:    drum_key = 7'd38;
            3'd3:    drum_key = 7'd41;
            3'd4:    drum_key = 7'd42;
            3'd5:    drum_key = 7'd46;
            3'd6:    drum_key = 7'd49;
            default: drum_key = 7'd35;
        endcase
    endfunction

endpackage

>>> src/note_grid_to_midi_events_unit.sv
// ----------------------------------------------------------------------------
// note_grid_to_midi_events_unit
// turns per-track note codes into midi note-on / note-off events
// ----------------------------------------------------------------------------
// grid channel: one beat per track per step, tracks ascending, step_end on
//   the last track of a step. grid_stall is high while a beat is in work.
// midi channel: zero, one or two event beats per grid beat, last_event set
//   on the final one. an output register holds the event, so the unit goes
//   back to take the next grid beat while the last event still waits.
// cfg port: cfg_write with cfg_index and cfg_data writes one register in a
//   cycle; write only while the unit is idle, the unit does not enforce it.
// sequence: a grid beat passes the load, scale walk, plan, emit and done
//   states, with a second emit when it makes two events; the walk is one
//   interval add a cycle on one adder, at most code-1 steps.
// reset: registers return to their defaults, no track is sounding and the
//   step count is zero.
// stall: a stalled event holds in the output register; the sequencer waits
//   for it to free before loading another event, and grid_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module note_grid_to_midi_events_unit
#(
    parameter int MAX_TRACKS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                grid_valid,
    output logic                                grid_stall,
    input  ngme_pkg::grid_t                     grid,
    output logic                                midi_valid,
    input  logic                                midi_stall,
    output ngme_pkg::midi_t                     midi,
    input  logic                                cfg_write,
    input  logic [ngme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ngme_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ngme_pkg::cfg_t cfg_reg;
    ngme_pkg::cmd_t cmd;
    ngme_pkg::sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_base       <= ngme_pkg::RST_SCALE_BASE;
            cfg_reg.scale_top        <= ngme_pkg::RST_SCALE_TOP;
            cfg_reg.scale_steps      <= ngme_pkg::RST_SCALE_STEPS;
            cfg_reg.scale_intervals  <= '0;
            cfg_reg.percussion_track <= '1;
            cfg_reg.track_offset     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ngme_pkg::CFG_SCALE_BASE:       cfg_reg.scale_base       <= cfg_data[6:0];
                ngme_pkg::CFG_SCALE_TOP:        cfg_reg.scale_top        <= cfg_data[6:0];
                ngme_pkg::CFG_SCALE_STEPS:      cfg_reg.scale_steps      <= cfg_data[3:0];
                ngme_pkg::CFG_SCALE_INTERVALS:  cfg_reg.scale_intervals  <= cfg_data[59:0];
                ngme_pkg::CFG_PERCUSSION_TRACK: cfg_reg.percussion_track <= cfg_data[8:0];
                ngme_pkg::CFG_TRACK_OFFSET:     cfg_reg.track_offset     <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    ngme_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .grid_valid (grid_valid),
        .grid_stall (grid_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    ngme_dp
    #(
        .MAX_TRACKS (MAX_TRACKS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .grid       (grid),
        .cmd        (cmd),
        .sts        (sts),
        .midi_valid (midi_valid),
        .midi_stall (midi_stall),
        .midi       (midi)
    );

endmodule

>>> src/ngme_ctrl.sv
// ----------------------------------------------------------------------------
// ngme_ctrl
// sequencer: accept a beat, walk the scale, plan and emit up to two events
// ----------------------------------------------------------------------------
`include "note_grid_to_midi_events_unit_macros.svh"

module ngme_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           grid_valid,
    output logic           grid_stall,
    input  ngme_pkg::sts_t sts,
    output ngme_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_PLAN   = 3'd2;
    localparam logic [2:0] ST_EMIT_A = 3'd3;
    localparam logic [2:0] ST_EMIT_B = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign grid_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (grid_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_PLAN;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = ST_EMIT_A;
            end
            ST_EMIT_A:
            begin
                if (sts.ev_count == 2'd0)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = (sts.ev_count == 2'd2) ? ST_EMIT_B : ST_DONE;
                end
            end
            ST_EMIT_B:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.second = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `NGME_ASSERT_NEXT(a_walk_holds, clk, rst_n, (state_reg == ST_WALK) && !sts.walk_done, state_reg == ST_WALK, "walk left before it finished")
    `NGME_ASSERT_NEXT(a_two_events, clk, rst_n, (state_reg == ST_EMIT_A) && sts.out_free && (sts.ev_count == 2'd2), state_reg == ST_EMIT_B, "second event skipped")
    `NGME_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "event loaded into a full output stage")

endmodule

>>> src/ngme_dp.sv
// ----------------------------------------------------------------------------
// ngme_dp
// datapath: item latch, scale walk, sounding keys, event plan, output stage
// ----------------------------------------------------------------------------
`include "note_grid_to_midi_events_unit_macros.svh"

module ngme_dp
#(
    parameter int MAX_TRACKS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  ngme_pkg::cfg_t  cfg,
    input  ngme_pkg::grid_t grid,
    input  ngme_pkg::cmd_t  cmd,
    output ngme_pkg::sts_t  sts,
    output logic            midi_valid,
    input  logic            midi_stall,
    output ngme_pkg::midi_t midi
);

    localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    // latched item
    logic [3:0]  trk_reg;
    logic [7:0]  code_reg;
    logic        end_reg;
    logic        drum_reg;
    logic [3:0]  ch_reg;

    // scale walk
    logic [6:0]  walk_key_reg;
    logic [8:0]  walk_i_reg;
    logic [3:0]  walk_pos_reg;
    logic [7:0]  walk_cnt_reg;

    // plan
    logic [1:0]  ev_count_reg;
    logic        first_on_reg;
    logic [6:0]  new_key_reg;
    logic [6:0]  old_key_reg;

    // sounding keys
    logic [MAX_TRACKS-1:0] sk_valid_reg;
    logic [6:0]            sk_key_reg [MAX_TRACKS];

    logic [27:0]     delta_reg;
    logic            midi_valid_reg;
    ngme_pkg::midi_t midi_reg;

    // channel map and drum detect on the incoming item
    logic [8:0] g;
    logic       p_pos;
    logic       drum_in;
    logic [4:0] ch5;
    logic [3:0] ch_in;

    always_comb
    begin
        g       = {5'b0, grid.track_index} + {1'b0, cfg.track_offset};
        p_pos   = !cfg.percussion_track[8];
        drum_in = p_pos && (g == cfg.percussion_track);
        ch5     = {1'b0, grid.track_index};
        if (p_pos && (g[3:0] == cfg.percussion_track[3:0]))
        begin
            if ({4'b0, grid.track_index} > cfg.percussion_track[7:0])
            begin
                ch5 = ch5 - 5'd1;
            end
            if (ch5 >= {1'b0, ngme_pkg::PERC_CHANNEL})
            begin
                ch5 = ch5 + 5'd1;
            end
        end
        ch_in = drum_in ? ngme_pkg::PERC_CHANNEL : ch5[3:0];
    end

    // scale walk step
    logic [3:0] n_eff;
    logic [4:0] iv [ngme_pkg::SCALE_SLOTS];
    logic [7:0] walk_sum;

    always_comb
    begin
        for (int s = 0; s < ngme_pkg::SCALE_SLOTS; s++)
        begin
            iv[s] = cfg.scale_intervals[s*ngme_pkg::IV_W +: ngme_pkg::IV_W];
        end
        if (cfg.scale_steps == 4'd0)
        begin
            n_eff = 4'd1;
        end
        else if (cfg.scale_steps > 4'(ngme_pkg::SCALE_SLOTS))
        begin
            n_eff = 4'(ngme_pkg::SCALE_SLOTS);
        end
        else
        begin
            n_eff = cfg.scale_steps;
        end
        walk_sum = {1'b0, walk_key_reg} + {3'b0, iv[walk_pos_reg]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            trk_reg      <= grid.track_index;
            code_reg     <= grid.note_code;
            end_reg      <= grid.step_end;
            drum_reg     <= drum_in;
            ch_reg       <= ch_in;
            walk_key_reg <= cfg.scale_base;
            walk_i_reg   <= '0;
            walk_pos_reg <= '0;
            // drums and rests need no walk
            walk_cnt_reg <= (drum_in || grid.note_code == 8'd0) ? 8'd0
                                                                : grid.note_code - 8'd1;
        end
        else if (cmd.step)
        begin
            if (walk_sum > {1'b0, cfg.scale_top})
            begin
                // overflow: back to base, skip the rest of this scale cycle
                walk_key_reg <= cfg.scale_base;
                walk_i_reg   <= walk_i_reg + {5'b0, n_eff - walk_pos_reg};
                walk_pos_reg <= '0;
            end
            else
            begin
                walk_key_reg <= walk_sum[6:0];
                walk_i_reg   <= walk_i_reg + 9'd1;
                walk_pos_reg <= (walk_pos_reg == n_eff - 4'd1) ? 4'd0 : walk_pos_reg + 4'd1;
            end
        end
    end

    // event plan
    logic          in_range;
    logic [TW-1:0] idx;
    logic          old_valid;
    logic [6:0]    old_key;
    logic          new_valid;
    logic [6:0]    new_key;
    logic          same;
    logic          off_first;
    logic [1:0]    plan_count;
    logic          plan_first_on;

    always_comb
    begin
        in_range      = ({1'b0, trk_reg} < 5'(MAX_TRACKS));
        idx           = trk_reg[TW-1:0];
        old_valid     = in_range && sk_valid_reg[idx];
        old_key       = sk_key_reg[idx];
        new_valid     = (code_reg != 8'd0);
        new_key       = '0;
        if (new_valid)
        begin
            new_key = drum_reg ? ngme_pkg::drum_key(ngme_pkg::mod7(code_reg)) : walk_key_reg;
        end
        same          = old_valid && new_valid && (old_key == new_key);
        off_first     = !new_valid || (old_valid && (old_key < new_key));
        plan_first_on = new_valid && !(old_valid && off_first);
        if (!in_range || same)
        begin
            plan_count = 2'd0;
        end
        else
        begin
            plan_count = {1'b0, old_valid} + {1'b0, new_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_count_reg <= '0;
        end
        else if (cmd.load)
        begin
            ev_count_reg <= '0;
        end
        else if (cmd.plan)
        begin
            ev_count_reg <= plan_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.plan)
        begin
            first_on_reg <= plan_first_on;
            new_key_reg  <= new_key;
            old_key_reg  <= old_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_valid_reg <= '0;
        end
        else if (cmd.plan && in_range)
        begin
            sk_valid_reg[idx] <= new_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.plan && in_range)
        begin
            sk_key_reg[idx] <= new_key;
        end
    end

    // output stage and step counter
    logic is_on;
    logic out_free;

    assign is_on    = cmd.second ? !first_on_reg : first_on_reg;
    assign out_free = !midi_valid_reg || !midi_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_valid_reg <= 1'b0;
            delta_reg      <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                midi_valid_reg <= 1'b1;
            end
            else if (!midi_stall)
            begin
                midi_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                delta_reg <= '0;
            end
            else if (cmd.finish && end_reg && (delta_reg != ngme_pkg::DELTA_MAX))
            begin
                delta_reg <= delta_reg + 28'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            midi_reg.delta_steps <= delta_reg;
            midi_reg.status_byte <= (is_on ? ngme_pkg::NOTE_ON : ngme_pkg::NOTE_OFF)
                                    | {4'b0, ch_reg};
            midi_reg.key         <= is_on ? new_key_reg : old_key_reg;
            midi_reg.velocity    <= is_on ? ngme_pkg::VEL_ON : ngme_pkg::VEL_OFF;
            midi_reg.last_event  <= cmd.second || (ev_count_reg == 2'd1);
        end
    end

    assign midi_valid    = midi_valid_reg;
    assign midi          = midi_reg;
    assign sts.walk_done = (walk_i_reg >= {1'b0, walk_cnt_reg});
    assign sts.out_free  = out_free;
    assign sts.ev_count  = ev_count_reg;

    `NGME_ASSERT_NEXT(a_delta_cleared, clk, rst_n, cmd.emit, delta_reg == 28'd0, "delta not cleared after an event")

endmodule

>>> tb/sv/note_grid_to_midi_events_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_grid_to_midi_events_unit_test
// self-checking bench for the note grid to midi event unit: a directed table
// of beats and register settings, then randomised steps under several scale
// and percussion settings. every midi beat is checked against expected events:
// those given in the table for typed rows, else a model of the sounding keys,
// the scale walk and the channel map kept in the bench
module note_grid_to_midi_events_unit_test;

    localparam int CFG_IDX_W   = ngme_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = ngme_pkg::CFG_DATA_W;
    localparam int IV_W        = ngme_pkg::IV_W;
    localparam int SCALE_SLOTS = ngme_pkg::SCALE_SLOTS;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int TRACKS         = 16;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 204;

    localparam logic [6:0] DRUM_KEYS [7] = '{7'd35, 7'd36, 7'd38, 7'd41, 7'd42, 7'd46, 7'd49};

    typedef struct {
        bit              is_cfg;
        ngme_pkg::cfg_t  setting;
        ngme_pkg::grid_t beat;
        bit              typed;
        int              n_ev;
        ngme_pkg::midi_t ev0;
        ngme_pkg::midi_t ev1;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  grid_valid = 1'b0;
    logic                  grid_stall;
    ngme_pkg::grid_t       grid = '0;
    logic                  midi_valid;
    logic                  midi_stall = 1'b0;
    ngme_pkg::midi_t       midi;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // bench-side tags travelling with the grid payload
    bit grid_typed = 1'b0;
    int grid_row = 0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int holds_taken = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    stim_row_t       directed_rows[$];
    ngme_pkg::midi_t pending_events[$];

    // model state
    ngme_pkg::cfg_t active_cfg;
    bit             track_sounding [TRACKS];
    logic [6:0]     track_key [TRACKS];
    logic [27:0]    steps_since_event;

    note_grid_to_midi_events_unit i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .grid_valid (grid_valid),
        .grid_stall (grid_stall),
        .grid       (grid),
        .midi_valid (midi_valid),
        .midi_stall (midi_stall),
        .midi       (midi),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic ngme_pkg::cfg_t make_setting(input logic [6:0] base,
                                                    input logic [6:0] top,
                                                    input logic [3:0] steps,
                                                    input logic [59:0] iv,
                                                    input logic [8:0] perc,
                                                    input logic [7:0] offs);
        ngme_pkg::cfg_t s;
        s.scale_base       = base;
        s.scale_top        = top;
        s.scale_steps      = steps;
        s.scale_intervals  = iv;
        s.percussion_track = perc;
        s.track_offset     = offs;
        return s;
    endfunction

    function automatic ngme_pkg::midi_t event_beat(input int delta, input logic [7:0] kind,
                                                   input logic [3:0] ch,
                                                   input logic [6:0] key_no, input bit last);
        ngme_pkg::midi_t e;
        e.delta_steps = 28'(delta);
        e.status_byte = kind | {4'd0, ch};
        e.key         = key_no;
        e.velocity    = (kind == ngme_pkg::NOTE_ON) ? ngme_pkg::VEL_ON : ngme_pkg::VEL_OFF;
        e.last_event  = last;
        return e;
    endfunction

    function automatic stim_row_t beat_row(input logic [3:0] trk, input logic [7:0] code,
                                           input bit fin);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.setting = '0;
        r.beat    = '{track_index: trk, note_code: code, step_end: fin};
        r.typed   = 1'b0;
        r.n_ev    = 0;
        r.ev0     = '0;
        r.ev1     = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [3:0] trk, input logic [7:0] code,
                                            input bit fin, input int n,
                                            input ngme_pkg::midi_t e0);
        stim_row_t r;
        r       = beat_row(trk, code, fin);
        r.typed = 1'b1;
        r.n_ev  = n;
        r.ev0   = e0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input ngme_pkg::cfg_t s);
        stim_row_t r;
        r         = beat_row(4'd0, 8'd0, 1'b0);
        r.is_cfg  = 1'b1;
        r.setting = s;
        return r;
    endfunction

    function automatic bit drum_track(input int unsigned trk);
        int p;
        p = $signed(active_cfg.percussion_track);
        return p >= 0 && int'(trk + active_cfg.track_offset) == p;
    endfunction

    function automatic logic [3:0] channel_for_track(input int unsigned trk);
        int g;
        int p;
        int ch;
        g  = trk + active_cfg.track_offset;
        p  = $signed(active_cfg.percussion_track);
        ch = trk;
        if (drum_track(trk))
            return ngme_pkg::PERC_CHANNEL;
        // the track that shares the drum channel's low nibble steps around channel 9
        if (p >= 0 && (g % 16) == (p % 16))
        begin
            if (ch > p)
                ch--;
            if (ch >= 9)
                ch++;
        end
        return ch[3:0];
    endfunction

    function automatic logic [6:0] scale_walk_key(input int unsigned count);
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        int unsigned key_no;
        n = active_cfg.scale_steps;
        if (n < 1)
            n = 1;
        if (n > SCALE_SLOTS)
            n = SCALE_SLOTS;
        key_no = active_cfg.scale_base;
        i      = 0;
        while (i < count)
        begin
            pos    = i % n;
            key_no += active_cfg.scale_intervals[IV_W*pos +: IV_W];
            // past the top: back to base and skip the rest of this cycle
            if (key_no > active_cfg.scale_top)
            begin
                key_no = active_cfg.scale_base;
                i      += n - pos;
            end
            else
                i++;
        end
        return key_no[6:0];
    endfunction

    function automatic ngme_pkg::midi_t note_event(input logic [7:0] kind,
                                                   input logic [3:0] ch,
                                                   input logic [6:0] key_no);
        ngme_pkg::midi_t e;
        e                 = event_beat(steps_since_event, kind, ch, key_no, 1'b0);
        steps_since_event = '0;
        return e;
    endfunction

    function automatic int advance_tracks(input ngme_pkg::grid_t beat,
                                          output ngme_pkg::midi_t first,
                                          output ngme_pkg::midi_t second);
        ngme_pkg::midi_t evs [2];
        int unsigned     trk;
        bit              now_on;
        bit              was_on;
        bit              off_first;
        logic [6:0]      old_key;
        logic [6:0]      new_key;
        logic [3:0]      ch;
        int              n;
        trk     = beat.track_index;
        n       = 0;
        evs[0]  = '0;
        evs[1]  = '0;
        now_on  = beat.note_code != 8'd0;
        was_on  = track_sounding[trk];
        old_key = track_key[trk];
        ch      = channel_for_track(trk);
        new_key = '0;
        if (now_on)
            new_key = drum_track(trk) ? DRUM_KEYS[beat.note_code % 7]
                                      : scale_walk_key(beat.note_code - 8'd1);
        if (!(was_on && now_on && old_key == new_key))
        begin
            off_first = !now_on || (was_on && old_key < new_key);
            if (was_on && off_first)
            begin
                evs[n] = note_event(ngme_pkg::NOTE_OFF, ch, old_key);
                n++;
            end
            if (now_on)
            begin
                evs[n] = note_event(ngme_pkg::NOTE_ON, ch, new_key);
                n++;
            end
            if (was_on && !off_first)
            begin
                evs[n] = note_event(ngme_pkg::NOTE_OFF, ch, old_key);
                n++;
            end
        end
        if (n > 0)
            evs[n-1].last_event = 1'b1;
        track_sounding[trk] = now_on;
        track_key[trk]      = new_key;
        if (beat.step_end && steps_since_event < ngme_pkg::DELTA_MAX)
            steps_since_event++;
        first  = evs[0];
        second = evs[1];
        return n;
    endfunction

    function automatic logic [7:0] pick_note_code();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return 8'd0;
        if (r < 95)
            return 8'($urandom_range(12, 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic ngme_pkg::cfg_t random_setting(input int kind);
        logic [59:0] iv;
        logic [6:0]  base;
        logic [6:0]  top;
        logic [3:0]  steps;
        logic [8:0]  perc;
        logic [7:0]  offs;
        int          span;
        span = (kind % 2) ? 31 : 6;
        for (int i = 0; i < SCALE_SLOTS; i++)
            iv[IV_W*i +: IV_W] = IV_W'($urandom_range(span));
        base = 7'($urandom_range(127));
        top  = (kind == 7) ? 7'($urandom_range(127)) : 7'($urandom_range(127, base));
        if (kind == 2)
            steps = 4'd0;
        else if (kind == 5)
            steps = 4'($urandom_range(15, 13));
        else
            steps = 4'($urandom_range(12, 1));
        if (kind == 0)
        begin
            base  = ngme_pkg::RST_SCALE_BASE;
            top   = ngme_pkg::RST_SCALE_TOP;
            steps = ngme_pkg::RST_SCALE_STEPS;
        end
        offs = (kind == 8) ? 8'($urandom_range(240)) : 8'($urandom_range(15) * 16);
        case ($urandom_range(3))
            0:       perc = 9'h1FF;
            1:       perc = 9'(offs + $urandom_range(15));
            2:       perc = {1'b0, 4'($urandom_range(15)), 4'(offs[3:0] + $urandom_range(15))};
            default: perc = 9'($urandom_range(255));
        endcase
        return make_setting(base, top, steps, iv, perc, offs);
    endfunction

    task automatic check_field(input string name, input logic [27:0] want,
                               input logic [27:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_setting(input ngme_pkg::cfg_t s);
        write_reg(ngme_pkg::CFG_SCALE_BASE, CFG_DATA_W'(s.scale_base));
        write_reg(ngme_pkg::CFG_SCALE_TOP, CFG_DATA_W'(s.scale_top));
        write_reg(ngme_pkg::CFG_SCALE_STEPS, CFG_DATA_W'(s.scale_steps));
        write_reg(ngme_pkg::CFG_SCALE_INTERVALS, CFG_DATA_W'(s.scale_intervals));
        write_reg(ngme_pkg::CFG_PERCUSSION_TRACK, CFG_DATA_W'(s.percussion_track));
        write_reg(ngme_pkg::CFG_TRACK_OFFSET, CFG_DATA_W'(s.track_offset));
        cfg_write <= 1'b0;
    endtask

    // wait out every outstanding event, then a walk's worth of cycles for beats
    // that make no event
    task automatic drain_events();
        grid_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic send_beat(input ngme_pkg::grid_t beat, input bit typed, input int row);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            grid_valid <= 1'b0;
            @(posedge clk);
        end
        grid       <= beat;
        grid_typed <= typed;
        grid_row   <= row;
        grid_valid <= 1'b1;
        @(posedge clk);
        while (grid_stall)
            @(posedge clk);
    endtask

    task automatic run_phase(input int items, input bit hold_off, input bit pause_midway);
        logic [3:0]      lanes[$];
        ngme_pkg::grid_t beat;
        int              sent;
        int              density;
        bit              paused;
        sent   = 0;
        paused = 1'b0;
        if (hold_off)
            hold_requests <= hold_requests + 1;
        while (sent < items)
        begin
            if (pause_midway && !paused && sent >= items / 2)
            begin
                drain_events();
                paused = 1'b1;
            end
            if ($urandom_range(9) == 0)
            begin
                // broken step: any track order, step_end anywhere
                repeat ($urandom_range(4, 1))
                begin
                    beat.track_index = 4'($urandom_range(15));
                    beat.note_code   = pick_note_code();
                    beat.step_end    = 1'($urandom_range(1));
                    send_beat(beat, 1'b0, 0);
                    sent++;
                end
            end
            else
            begin
                lanes.delete();
                density = $urandom_range(90, 10);
                for (int t = 0; t < TRACKS; t++)
                    if ($urandom_range(99) < density)
                        lanes.push_back(4'(t));
                if (lanes.size() == 0)
                    lanes.push_back(4'($urandom_range(15)));
                foreach (lanes[j])
                begin
                    beat.track_index = lanes[j];
                    beat.note_code   = pick_note_code();
                    beat.step_end    = (j == lanes.size() - 1);
                    send_beat(beat, 1'b0, 0);
                    sent++;
                end
            end
        end
    endtask

    // receiver: random stall, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_stall  <= 1'b0;
            hold_left   <= 0;
            holds_taken <= 0;
        end
        else if (holds_taken != hold_requests)
        begin
            holds_taken <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            midi_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left  <= hold_left - 1;
            midi_stall <= 1'b1;
        end
        else
            midi_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        ngme_pkg::midi_t first;
        ngme_pkg::midi_t second;
        ngme_pkg::midi_t want;
        int              n;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ngme_pkg::CFG_SCALE_BASE:
                        active_cfg.scale_base       = cfg_data[6:0];
                    ngme_pkg::CFG_SCALE_TOP:
                        active_cfg.scale_top        = cfg_data[6:0];
                    ngme_pkg::CFG_SCALE_STEPS:
                        active_cfg.scale_steps      = cfg_data[3:0];
                    ngme_pkg::CFG_SCALE_INTERVALS:
                        active_cfg.scale_intervals  = cfg_data[59:0];
                    ngme_pkg::CFG_PERCUSSION_TRACK:
                        active_cfg.percussion_track = cfg_data[8:0];
                    ngme_pkg::CFG_TRACK_OFFSET:
                        active_cfg.track_offset     = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (grid_valid && !grid_stall)
            begin
                n = advance_tracks(grid, first, second);
                if (grid_typed)
                begin
                    if (directed_rows[grid_row].n_ev > 0)
                        pending_events.push_back(directed_rows[grid_row].ev0);
                    if (directed_rows[grid_row].n_ev > 1)
                        pending_events.push_back(directed_rows[grid_row].ev1);
                end
                else
                begin
                    if (n > 0)
                        pending_events.push_back(first);
                    if (n > 1)
                        pending_events.push_back(second);
                end
            end
            if (midi_valid && !midi_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t ns: event beat with none expected, got %h", $time, midi);
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("delta_steps", want.delta_steps, midi.delta_steps);
                    check_field("status_byte", 28'(want.status_byte), 28'(midi.status_byte));
                    check_field("key", 28'(want.key), 28'(midi.key));
                    check_field("velocity", 28'(want.velocity), 28'(midi.velocity));
                    check_field("last_event", 28'(want.last_event), 28'(midi.last_event));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((grid_valid && !grid_stall) || (midi_valid && !midi_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        active_cfg = make_setting(ngme_pkg::RST_SCALE_BASE, ngme_pkg::RST_SCALE_TOP,
                                  ngme_pkg::RST_SCALE_STEPS, 60'd0, 9'h1FF, 8'd0);
        foreach (track_sounding[t])
        begin
            track_sounding[t] = 1'b0;
            track_key[t]      = '0;
        end
        steps_since_event = '0;

        // reset settings: flat scale, every note lands on the base key
        directed_rows.push_back(typed_row(4'd0, 8'd1, 1'b0, 1,
                                          event_beat(0, ngme_pkg::NOTE_ON, 4'd0, 7'd60, 1'b1)));
        directed_rows.push_back(typed_row(4'd0, 8'd255, 1'b1, 0, '0));
        directed_rows.push_back(typed_row(4'd15, 8'd0, 1'b1, 0, '0));
        directed_rows.push_back(typed_row(4'd15, 8'd2, 1'b1, 1,
                                          event_beat(2, ngme_pkg::NOTE_ON, 4'd15, 7'd60, 1'b1)));
        directed_rows.push_back(typed_row(4'd0, 8'd0, 1'b0, 1,
                                          event_beat(1, ngme_pkg::NOTE_OFF, 4'd0, 7'd60, 1'b1)));
        directed_rows.push_back(typed_row(4'd15, 8'd0, 1'b1, 1,
                                          event_beat(0, ngme_pkg::NOTE_OFF, 4'd15, 7'd60, 1'b1)));
        // widest intervals: walk up, then overflow back to base; drums on track 9
        directed_rows.push_back(cfg_row(make_setting(7'd0, 7'd127, 4'd12, {60{1'b1}},
                                                     9'd9, 8'd0)));
        directed_rows.push_back(beat_row(4'd3, 8'd1, 1'b0));
        directed_rows.push_back(beat_row(4'd3, 8'd5, 1'b0));
        directed_rows.push_back(beat_row(4'd3, 8'd6, 1'b0));
        directed_rows.push_back(beat_row(4'd9, 8'd7, 1'b0));
        directed_rows.push_back(beat_row(4'd9, 8'd13, 1'b0));
        directed_rows.push_back(beat_row(4'd9, 8'd255, 1'b1));
        // base above top, zero steps, no percussion
        directed_rows.push_back(cfg_row(make_setting(7'd127, 7'd0, 4'd0, 60'd0,
                                                     9'h1FF, 8'd240)));
        directed_rows.push_back(beat_row(4'd0, 8'd1, 1'b0));
        directed_rows.push_back(beat_row(4'd0, 8'd3, 1'b0));
        directed_rows.push_back(beat_row(4'd15, 8'd200, 1'b1));
        // highest percussion track, steps beyond the slot count
        directed_rows.push_back(cfg_row(make_setting(7'd30, 7'd90, 4'd15,
                                                     60'h0123_4567_89AB_CDE, 9'd255, 8'd240)));
        directed_rows.push_back(beat_row(4'd15, 8'd8, 1'b0));
        directed_rows.push_back(beat_row(4'd14, 8'd100, 1'b0));
        directed_rows.push_back(beat_row(4'd15, 8'd0, 1'b1));
        // percussion outside this block's tracks but on track 9's nibble
        directed_rows.push_back(cfg_row(make_setting(7'd60, 7'd127, 4'd7,
            {25'd0, 5'd1, 5'd2, 5'd2, 5'd2, 5'd1, 5'd2, 5'd2}, 9'd41, 8'd16)));
        directed_rows.push_back(beat_row(4'd9, 8'd10, 1'b0));
        directed_rows.push_back(beat_row(4'd9, 8'd10, 1'b1));
        directed_rows.push_back(beat_row(4'd9, 8'd0, 1'b1));

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct <= 24;
        rx_idle_pct <= 75;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
            begin
                drain_events();
                apply_setting(directed_rows[r].setting);
            end
            else
                send_beat(directed_rows[r].beat, directed_rows[r].typed, r);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_events();
            apply_setting(random_setting(p));
            if (p == 3)
            begin
                tx_idle_pct <= 75;
                rx_idle_pct <= 24;
            end
            else if (p == 6)
            begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            run_phase(PHASE_ITEMS, p == 1, p == 4);
        end

        drain_events();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
